/* src/pll_angle_speed_estimator_macros.svh */
// Assertion macros for the RTL; the top-level estimator file includes them.
`ifndef PLL_ANGLE_SPEED_ESTIMATOR_MACROS_SVH
`define PLL_ANGLE_SPEED_ESTIMATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every clock edge outside reset.
`define PAE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define PAE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Antecedent implies consequent in the next cycle.
`define PAE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define PAE_ASSERT(lbl, cond)
`define PAE_ASSERT_IMP(lbl, ante, cons)
`define PAE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* src/pae_pkg.sv */
package pae_pkg;

    localparam int ANGLE_BITS_DEF       = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    localparam int SAMPLE_W = 16;
    localparam int SPEED_W  = 32;
    localparam int GAIN_W   = 24;
    localparam int TURNS_W  = 32;
    localparam int CLAMP_W  = 31;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 4;

    localparam int MUL_A_W         = 34;
    localparam int MUL_B_W         = 32;
    localparam int MUL_P_W         = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W       = $clog2(MUL_B_W);
    localparam int MUL_SHORT_STEPS = 16;
    localparam int MUL_LONG_STEPS  = 32;

    typedef enum logic [1:0] {
        REG_KP,
        REG_KI_TS,
        REG_TS_TURNS,
        REG_SPEED_CLAMP
    } pae_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REQ_COS,
        S_REQ_SIN,
        S_BC,
        S_AS,
        S_ERR,
        S_KI,
        S_INTEG,
        S_KP,
        S_OMEGA,
        S_TS_GO,
        S_TS,
        S_ANGLE,
        S_OUT
    } pae_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] emf_alpha;
        logic signed [SAMPLE_W-1:0] emf_beta;
        logic                       restart;
    } emf_in_t;

    typedef struct packed {
        logic [15:0]               angle_est;
        logic signed [SPEED_W-1:0] speed_est;
    } est_out_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki_ts;
        logic [TURNS_W-1:0] ts_turns;
        logic [CLAMP_W-1:0] speed_clamp;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic long_op;
        logic b_signed;
    } mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

/* src/pae_apb_regs.sv */
module pae_apb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pae_pkg::PADDR_W-1:0]  paddr,
    input  logic [pae_pkg::APB_W-1:0]    pwdata,
    output logic [pae_pkg::APB_W-1:0]    prdata,
    output logic                         pready,
    output pae_pkg::cfg_t                cfg
);
    import pae_pkg::*;

    logic [GAIN_W-1:0]  kp_reg;
    logic [GAIN_W-1:0]  ki_ts_reg;
    logic [TURNS_W-1:0] ts_turns_reg;
    logic [CLAMP_W-1:0] speed_clamp_reg;
    pae_reg_t           sel;
    logic               wr;

    assign sel    = pae_reg_t'(paddr[PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg          <= GAIN_W'(65536);
            ki_ts_reg       <= '0;
            ts_turns_reg    <= '0;
            speed_clamp_reg <= '1;
        end
        else if (wr)
        begin
            unique case (sel)
                REG_KP:          kp_reg          <= pwdata[GAIN_W-1:0];
                REG_KI_TS:       ki_ts_reg       <= pwdata[GAIN_W-1:0];
                REG_TS_TURNS:    ts_turns_reg    <= pwdata[TURNS_W-1:0];
                REG_SPEED_CLAMP: speed_clamp_reg <= pwdata[CLAMP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_KP:          prdata = APB_W'(kp_reg);
            REG_KI_TS:       prdata = APB_W'(ki_ts_reg);
            REG_TS_TURNS:    prdata = APB_W'(ts_turns_reg);
            REG_SPEED_CLAMP: prdata = APB_W'(speed_clamp_reg);
        endcase
    end

    assign cfg.kp          = kp_reg;
    assign cfg.ki_ts       = ki_ts_reg;
    assign cfg.ts_turns    = ts_turns_reg;
    assign cfg.speed_clamp = speed_clamp_reg;

endmodule

/* src/pae_sine_rom.sv */
module pae_sine_rom #(
    parameter int ANGLE_BITS       = pae_pkg::ANGLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = pae_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic [ANGLE_BITS-1:0]              angle,
    input  logic                               sel_cos,
    output logic signed [pae_pkg::SAMPLE_W-1:0] value
);
    import pae_pkg::*;

    localparam int IDX_W  = ANGLE_BITS + $clog2(4 * SINE_TABLE_DEPTH) + 1;
    localparam int POS_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);

    function automatic logic [14:0] sine_val(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = ((HALF_PI_Q32 * 64'(k)) / SINE_TABLE_DEPTH) >> 2;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s[14:0];
    endfunction

    logic [14:0]                sine_tab [SINE_TABLE_DEPTH + 1];
    logic [IDX_W-1:0]           scaled;
    logic [IDX_W-1:0]           idx;
    logic [IDX_W-1:0]           pos_full;
    logic [POS_W-1:0]           pos;
    logic [1:0]                 quad;
    logic [1:0]                 quad_eff;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] value_next;
    logic signed [SAMPLE_W-1:0] value_reg;

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_tab
        assign sine_tab[k] = sine_val(k);
    end

    assign scaled   = IDX_W'(angle) * IDX_W'(4 * SINE_TABLE_DEPTH);
    assign idx      = scaled >> ANGLE_BITS;
    assign quad     = angle[ANGLE_BITS-1 -: 2];
    assign pos_full = idx - IDX_W'(quad) * IDX_W'(SINE_TABLE_DEPTH);
    assign pos      = pos_full[POS_W-1:0];
    assign quad_eff = quad + {1'b0, sel_cos};
    assign addr     = quad_eff[0] ? ADDR_W'(SINE_TABLE_DEPTH) - ADDR_W'(pos) : ADDR_W'(pos);

    always_comb
    begin
        if (quad_eff[1])
        begin
            value_next = -$signed({1'b0, sine_tab[addr]});
        end
        else
        begin
            value_next = $signed({1'b0, sine_tab[addr]});
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* src/pae_smul.sv */
module pae_smul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pae_pkg::mul_ctl_t                   ctl,
    input  logic signed [pae_pkg::MUL_A_W-1:0]  a,
    input  logic [pae_pkg::MUL_B_W-1:0]         b,
    output pae_pkg::mul_stat_t                  stat,
    output logic signed [pae_pkg::MUL_P_W-1:0]  product
);
    import pae_pkg::*;

    logic signed [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0]        b_reg;
    logic signed [MUL_A_W-1:0] hi_reg;
    logic [MUL_B_W-1:0]        lo_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic                      long_reg;
    logic                      bsgn_reg;
    logic signed [MUL_A_W-1:0] term;
    logic signed [MUL_A_W:0]   sum;
    logic                      last_step;

    assign last_step = (cnt_reg == '0);

    always_comb
    begin
        if (!b_reg[0])
        begin
            term = '0;
        end
        else if (bsgn_reg && last_step)
        begin
            term = -a_reg;
        end
        else
        begin
            term = a_reg;
        end
        sum = {hi_reg[MUL_A_W-1], hi_reg} + {term[MUL_A_W-1], term};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            long_reg <= 1'b0;
            bsgn_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (ctl.start)
            begin
                busy_reg <= 1'b1;
                long_reg <= ctl.long_op;
                bsgn_reg <= ctl.b_signed;
                cnt_reg  <= ctl.long_op ? MUL_CNT_W'(MUL_LONG_STEPS - 1)
                                        : MUL_CNT_W'(MUL_SHORT_STEPS - 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            hi_reg <= sum[MUL_A_W:1];
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
            b_reg  <= b_reg >> 1;
        end
        else if (ctl.start)
        begin
            a_reg  <= a;
            b_reg  <= b;
            hi_reg <= '0;
            lo_reg <= '0;
        end
    end

    always_comb
    begin
        if (long_reg)
        begin
            product = {hi_reg, lo_reg};
        end
        else
        begin
            product = {{(MUL_B_W - MUL_SHORT_STEPS){hi_reg[MUL_A_W-1]}}, hi_reg,
                       lo_reg[MUL_B_W-1 -: MUL_SHORT_STEPS]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* src/pll_angle_speed_estimator.sv */
// Channel   Direction  Payload     Handshake
// sample    in         emf_in_t    sample_valid / sample_stall
// result    out        est_out_t   result_valid / result_stall
// apb       in/out     32-bit reg  psel / penable / pwrite / pready
//
// Each sample is paced by the bit-serial shift-add multiplier: four 16-step
// products (error terms and PI gains) and one 32-step product (angle step),
// plus table lookup and saturation.
// Reset clears the angle, speed and integrator; the restart bit does the same.
// A sample is taken only when the core is idle; a finished word may wait in
// the output register while the next sample is accepted and processed.
module pll_angle_speed_estimator #(
    parameter int ANGLE_BITS       = pae_pkg::ANGLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = pae_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  pae_pkg::emf_in_t            sample,
    output logic                        result_valid,
    input  logic                        result_stall,
    output pae_pkg::est_out_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pae_pkg::PADDR_W-1:0] paddr,
    input  logic [pae_pkg::APB_W-1:0]   pwdata,
    output logic [pae_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);
    import pae_pkg::*;

`include "pll_angle_speed_estimator_macros.svh"

    localparam int SH = 48 - ANGLE_BITS;

    cfg_t                       cfg;
    mul_ctl_t                   mul_ctl;
    mul_stat_t                  mul_stat;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    logic signed [SAMPLE_W-1:0] rom_value;
    logic                       rom_sel_cos;

    pae_state_t                 state_reg, state_next;
    logic [ANGLE_BITS-1:0]      angle_reg, angle_next;
    logic signed [SPEED_W-1:0]  speed_reg, speed_next;
    logic signed [SPEED_W-1:0]  integ_reg, integ_next;
    logic                       result_valid_reg, result_valid_next;

    logic signed [SAMPLE_W-1:0] alpha_reg, alpha_next;
    logic signed [SAMPLE_W-1:0] beta_reg, beta_next;
    logic signed [SAMPLE_W-1:0] sin_reg, sin_next;
    logic signed [32:0]         bc_reg, bc_next;
    logic signed [SAMPLE_W-1:0] err_reg, err_next;
    logic signed [25:0]         term_reg, term_next;
    logic [ANGLE_BITS-1:0]      delta_reg, delta_next;
    est_out_t                   result_reg, result_next;

    logic signed [33:0]         err_raw;
    logic signed [18:0]         err_rnd;
    logic signed [40:0]         gain_rnd;
    logic signed [32:0]         sum33;
    logic signed [32:0]         clamp33;
    logic [SPEED_W-1:0]         speed_mag;
    logic [63:0]                step_sum;
    logic [15:0]                angle_out;

    pae_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pae_sine_rom #(
        .ANGLE_BITS       (ANGLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk     (clk),
        .angle   (angle_reg),
        .sel_cos (rom_sel_cos),
        .value   (rom_value)
    );

    pae_smul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .a       (mul_a),
        .b       (mul_b),
        .stat    (mul_stat),
        .product (mul_p)
    );

    if (ANGLE_BITS >= 16)
    begin : g_out_wide
        assign angle_out = angle_reg[ANGLE_BITS-1 -: 16];
    end
    else
    begin : g_out_narrow
        assign angle_out = {angle_reg, {(16 - ANGLE_BITS){1'b0}}};
    end

    assign rom_sel_cos  = (state_reg == S_REQ_COS);
    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign err_raw   = {bc_reg[32], bc_reg} - {mul_p[32], mul_p[32:0]};
    assign err_rnd   = 19'((err_raw + 34'sd16384) >>> 15);
    assign gain_rnd  = mul_p[40:0] + 41'sd16384;
    assign clamp33   = $signed({2'b00, cfg.speed_clamp});
    assign speed_mag = speed_reg[SPEED_W-1] ? SPEED_W'(-speed_reg) : SPEED_W'(speed_reg);
    assign step_sum  = {1'b0, mul_p[62:0]} + (64'd1 << (SH - 1));

    always_comb
    begin
        state_next        = state_reg;
        angle_next        = angle_reg;
        speed_next        = speed_reg;
        integ_next        = integ_reg;
        result_valid_next = result_valid_reg;
        alpha_next        = alpha_reg;
        beta_next         = beta_reg;
        sin_next          = sin_reg;
        bc_next           = bc_reg;
        err_next          = err_reg;
        term_next         = term_reg;
        delta_next        = delta_reg;
        result_next       = result_reg;
        mul_ctl           = '0;
        mul_a             = '0;
        mul_b             = '0;
        sum33             = '0;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    alpha_next = sample.emf_alpha;
                    beta_next  = sample.emf_beta;
                    if (sample.restart)
                    begin
                        angle_next = '0;
                        speed_next = '0;
                        integ_next = '0;
                    end
                    state_next = S_REQ_COS;
                end
            end
            S_REQ_COS:
            begin
                state_next = S_REQ_SIN;
            end
            S_REQ_SIN:
            begin
                mul_ctl.start    = 1'b1;
                mul_ctl.b_signed = 1'b1;
                mul_a            = MUL_A_W'(beta_reg);
                mul_b            = MUL_B_W'(rom_value);
                state_next       = S_BC;
            end
            S_BC:
            begin
                sin_next = rom_value;
                if (mul_stat.done)
                begin
                    bc_next          = mul_p[32:0];
                    mul_ctl.start    = 1'b1;
                    mul_ctl.b_signed = 1'b1;
                    mul_a            = MUL_A_W'(alpha_reg);
                    mul_b            = MUL_B_W'(sin_reg);
                    state_next       = S_AS;
                end
            end
            S_AS:
            begin
                if (mul_stat.done)
                begin
                    if (err_rnd > 19'sd32767)
                    begin
                        err_next = 16'sh7FFF;
                    end
                    else if (err_rnd < -19'sd32768)
                    begin
                        err_next = 16'sh8000;
                    end
                    else
                    begin
                        err_next = err_rnd[15:0];
                    end
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                mul_ctl.start    = 1'b1;
                mul_ctl.b_signed = 1'b1;
                mul_a            = $signed(MUL_A_W'(cfg.ki_ts));
                mul_b            = MUL_B_W'(err_reg);
                state_next       = S_KI;
            end
            S_KI:
            begin
                if (mul_stat.done)
                begin
                    term_next  = gain_rnd[40:15];
                    state_next = S_INTEG;
                end
            end
            S_INTEG:
            begin
                sum33 = 33'(integ_reg) + 33'(term_reg);
                if (sum33[32] != sum33[31])
                begin
                    integ_next = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                else
                begin
                    integ_next = sum33[31:0];
                end
                mul_ctl.start    = 1'b1;
                mul_ctl.b_signed = 1'b1;
                mul_a            = $signed(MUL_A_W'(cfg.kp));
                mul_b            = MUL_B_W'(err_reg);
                state_next       = S_KP;
            end
            S_KP:
            begin
                if (mul_stat.done)
                begin
                    term_next  = gain_rnd[40:15];
                    state_next = S_OMEGA;
                end
            end
            S_OMEGA:
            begin
                sum33 = 33'(integ_reg) + 33'(term_reg);
                if (sum33 > clamp33)
                begin
                    speed_next = clamp33[31:0];
                end
                else if (sum33 < -clamp33)
                begin
                    speed_next = 32'(-clamp33);
                end
                else
                begin
                    speed_next = sum33[31:0];
                end
                state_next = S_TS_GO;
            end
            S_TS_GO:
            begin
                mul_ctl.start   = 1'b1;
                mul_ctl.long_op = 1'b1;
                mul_a           = $signed(MUL_A_W'(cfg.ts_turns));
                mul_b           = speed_mag;
                state_next      = S_TS;
            end
            S_TS:
            begin
                if (mul_stat.done)
                begin
                    delta_next = step_sum[SH +: ANGLE_BITS];
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                if (speed_reg[SPEED_W-1])
                begin
                    angle_next = angle_reg - delta_reg;
                end
                else
                begin
                    angle_next = angle_reg + delta_reg;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.angle_est = angle_out;
                    result_next.speed_est = speed_reg;
                    result_valid_next     = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            angle_reg        <= '0;
            speed_reg        <= '0;
            integ_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            angle_reg        <= angle_next;
            speed_reg        <= speed_next;
            integ_reg        <= integ_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_reg  <= alpha_next;
        beta_reg   <= beta_next;
        sin_reg    <= sin_next;
        bc_reg     <= bc_next;
        err_reg    <= err_next;
        term_reg   <= term_next;
        delta_reg  <= delta_next;
        result_reg <= result_next;
    end

    `PAE_ASSERT_IMP(a_mul_start_free, mul_ctl.start, !mul_stat.busy)
    `PAE_ASSERT_IMP(a_mul_done_state, mul_stat.done, state_reg == S_BC || state_reg == S_AS || state_reg == S_KI || state_reg == S_KP || state_reg == S_TS)
    `PAE_ASSERT_IMP(a_mul_busy_not_idle, mul_stat.busy, state_reg != S_IDLE)
    `PAE_ASSERT_NXT(a_result_loaded, state_reg == S_OUT && state_next == S_IDLE, result_valid_reg)

endmodule
